// ===== sv/idfe_pkg.sv =====
// ----------------------------------------------------------------------------
// idfe_pkg: shared types and constants of the tag frame extractor
// Item and result layouts, configuration layout, result kinds and register
// indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package idfe_pkg;

  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_MODE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_ID   = 8'd1;

  localparam logic [1:0] KIND_START     = 2'd0;
  localparam logic [1:0] KIND_BODY      = 2'd1;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  localparam logic [3:0] HEADER_BYTES  = 4'd10;
  localparam logic [3:0] TAG_SIZE_POS  = 4'd6;
  localparam logic [3:0] ID_BYTES      = 4'd4;
  localparam logic [3:0] SIZE_BYTES    = 4'd4;
  localparam logic [3:0] FLAG_BYTES    = 4'd3;
  localparam logic [28:0] FRAME_OVERHEAD = 29'd11;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] frame_id;
    logic [7:0]  content_byte;
    logic        last_of_frame;
  } result_t;

  // Input item as classified by the front end.
  typedef struct packed {
    item_t item;
    logic  is_upper;
  } cls_item_t;

  typedef struct packed {
    logic        select_mode;
    logic [31:0] wanted_id;
  } cfg_t;

  function automatic cls_item_t classify(item_t it);
    cls_item_t c;
    c.item     = it;
    c.is_upper = (it.data_byte >= CHAR_A) && (it.data_byte <= CHAR_Z);
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/idfe_fifo.sv =====
// ----------------------------------------------------------------------------
// idfe_fifo: small show-ahead queue
// Flip-flop storage; the head entry is visible while empty is low.
// ----------------------------------------------------------------------------
`default_nettype none

module idfe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/idfe_parser.sv =====
// ----------------------------------------------------------------------------
// idfe_parser: tag and frame walker
// Takes one classified byte per step and produces at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module idfe_parser
  import idfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  input  wire cls_item_t in_data,
  output logic           in_pop,
  input  wire logic      out_full,
  output logic           out_push,
  output result_t        out_data
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_ID, PH_SIZE, PH_FLAGS, PH_BODY, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [28:0] tag_remaining, tag_remaining_next;
  logic [31:0] current_id, current_id_next;
  logic [27:0] frame_length, frame_length_next;
  logic [27:0] body_remaining, body_remaining_next;
  logic        frame_matches, frame_matches_next;
  logic [28:0] frame_cost, frame_cost_next;

  logic        step;
  logic        emit;
  logic        frame_done;
  result_t     res;
  logic [6:0]  b7;
  logic [7:0]  b;

  assign step     = in_valid && !out_full;
  assign in_pop   = step;
  assign out_push = step && emit;
  assign out_data = res;
  assign b        = in_data.item.data_byte;
  assign b7       = b[6:0];

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    tag_remaining_next  = tag_remaining;
    current_id_next     = current_id;
    frame_length_next   = frame_length;
    body_remaining_next = body_remaining;
    frame_matches_next  = frame_matches;
    frame_cost_next     = frame_cost;
    emit                = 1'b0;
    frame_done          = 1'b0;
    res                 = '0;

    if (in_data.item.new_file) begin
      phase_next          = PH_HEADER;
      byte_position_next  = '0;
      tag_remaining_next  = '0;
      current_id_next     = '0;
      frame_length_next   = '0;
      body_remaining_next = '0;
      frame_matches_next  = 1'b0;
    end

    case (phase_next)
      PH_HEADER: begin
        if (byte_position_next == TAG_SIZE_POS) begin
          tag_remaining_next = {22'd0, b7};
        end else if (byte_position_next > TAG_SIZE_POS) begin
          tag_remaining_next = {tag_remaining_next[21:0], b7};
        end
        byte_position_next = byte_position_next + 1'b1;
        if (byte_position_next >= HEADER_BYTES) begin
          byte_position_next = '0;
          phase_next         = PH_ID;
          if (tag_remaining_next == '0) begin
            phase_next = PH_DONE;
            emit       = cfg.select_mode;
          end
        end
      end
      PH_ID: begin
        if (byte_position_next == '0 && !in_data.is_upper) begin
          phase_next = PH_DONE;
          emit       = cfg.select_mode;
        end else begin
          current_id_next    = {current_id_next[23:0], b};
          byte_position_next = byte_position_next + 1'b1;
          if (byte_position_next >= ID_BYTES) begin
            byte_position_next = '0;
            frame_length_next  = '0;
            phase_next         = PH_SIZE;
          end
        end
      end
      PH_SIZE: begin
        frame_length_next  = {frame_length_next[20:0], b7};
        byte_position_next = byte_position_next + 1'b1;
        if (byte_position_next >= SIZE_BYTES) begin
          byte_position_next = '0;
          phase_next         = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        // The frame cost is worked out on the first flag byte, ahead of use.
        if (byte_position_next == '0) begin
          frame_cost_next = (frame_length_next != '0) ?
                            {1'b0, frame_length_next} + 29'd10 : FRAME_OVERHEAD;
        end
        byte_position_next = byte_position_next + 1'b1;
        if (byte_position_next >= FLAG_BYTES) begin
          byte_position_next  = '0;
          body_remaining_next = (frame_length_next != '0) ?
                                frame_length_next - 1'b1 : '0;
          frame_matches_next  = (current_id_next == cfg.wanted_id);
          if (!cfg.select_mode || frame_matches_next) begin
            emit              = 1'b1;
            res.kind          = KIND_START;
            res.frame_id      = current_id_next;
            res.last_of_frame = (body_remaining_next == '0);
          end
          if (body_remaining_next == '0) begin
            frame_done = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (!cfg.select_mode || frame_matches_next) begin
          emit              = 1'b1;
          res.kind          = KIND_BODY;
          res.frame_id      = current_id_next;
          res.content_byte  = b;
          res.last_of_frame = (body_remaining_next == 28'd1);
        end
        if (body_remaining_next != '0) begin
          body_remaining_next = body_remaining_next - 1'b1;
        end
        if (body_remaining_next == '0) begin
          frame_done = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Frame bookkeeping: a matched frame in get mode stops the walk,
    // otherwise its cost comes off the tag size, saturating at zero.
    if (frame_done) begin
      if (cfg.select_mode && frame_matches_next) begin
        phase_next = PH_DONE;
      end else begin
        tag_remaining_next = (tag_remaining_next > frame_cost_next) ?
                             tag_remaining_next - frame_cost_next : '0;
        phase_next         = PH_ID;
        byte_position_next = '0;
        if (tag_remaining_next == '0) begin
          phase_next = PH_DONE;
          if (!emit) begin
            emit = cfg.select_mode;
          end
        end
      end
    end

    // Not-found report in get mode whenever the walk ends with no other result.
    if (emit && phase_next == PH_DONE && !frame_done) begin
      res.kind          = KIND_NOT_FOUND;
      res.frame_id      = cfg.wanted_id;
      res.content_byte  = '0;
      res.last_of_frame = 1'b1;
    end else if (emit && frame_done && phase_next == PH_DONE &&
                 !(res.kind == KIND_START || res.kind == KIND_BODY)) begin
      res.kind = KIND_NOT_FOUND;
    end
    if (frame_done && phase_next == PH_DONE && emit &&
        !(cfg.select_mode && frame_matches_next) &&
        !(!cfg.select_mode || frame_matches_next)) begin
      res.kind          = KIND_NOT_FOUND;
      res.frame_id      = cfg.wanted_id;
      res.content_byte  = '0;
      res.last_of_frame = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_position  <= '0;
      tag_remaining  <= '0;
      current_id     <= '0;
      frame_length   <= '0;
      body_remaining <= '0;
      frame_matches  <= 1'b0;
      frame_cost     <= FRAME_OVERHEAD;
    end else if (step) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      tag_remaining  <= tag_remaining_next;
      current_id     <= current_id_next;
      frame_length   <= frame_length_next;
      body_remaining <= body_remaining_next;
      frame_matches  <= frame_matches_next;
      frame_cost     <= frame_cost_next;
    end
  end

  a_not_found_in_get_mode: assert property (@(posedge clk) disable iff (rst)
    (out_push && out_data.kind == KIND_NOT_FOUND) |-> cfg.select_mode)
    else $error("not-found result outside get mode");

  a_not_found_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (out_push && out_data.kind == KIND_NOT_FOUND) |=> (phase == PH_DONE))
    else $error("walk continues after a not-found result");

  a_quiet_when_done: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_DONE && !in_data.item.new_file) |-> !out_push)
    else $error("result produced after the end of the tag");

  a_body_needs_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_remaining != '0))
    else $error("body phase with nothing left to read");

endmodule

`default_nettype wire

// ===== sv/id3v2_frame_extractor.sv =====
// ----------------------------------------------------------------------------
// id3v2_frame_extractor: tag frame extractor, top level
// Byte-stream front end, frame walker and result queue.
// ----------------------------------------------------------------------------
// The block takes the bytes of a tagged audio file, one byte per transfer,
// and sustains one byte per clock cycle as long as results are taken. Each
// byte is classified as it comes in and waits in a short input queue; the
// frame walker takes one byte from that queue in every cycle in which the
// result queue has room, so a byte is registered in the input queue and its
// result in the result queue before that result is on the result ports.
// The walker itself is a counter update and one
// subtract-and-compare per byte, and that single step is what sets the rate.
// A byte with new_file high restarts parsing at the tag header. Configuration
// should be written only while no transferred byte is still in flight.
`default_nettype none

module id3v2_frame_extractor
  import idfe_pkg::*;
#(
  parameter int IN_DEPTH  = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire item_t                  item,
  input  wire logic                   pop,
  output logic                        empty,
  output result_t                     result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);

  cfg_t      cfg;
  cls_item_t cls_in;
  cls_item_t cls_head;
  logic      in_empty;
  logic      in_pop;
  logic      out_full;
  logic      out_push;
  result_t   out_data;

  // Registers accept a write in every cycle; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SELECT_MODE: cfg.select_mode <= cfg_data[0];
        CFG_WANTED_ID:   cfg.wanted_id   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: classify the byte on the way into the input queue.
  assign cls_in = classify(item);

  idfe_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cls_in),
    .full    (full),
    .pop     (in_pop),
    .rd_data (cls_head),
    .empty   (in_empty)
  );

  // Back end: the walker advances only when a result would have a place.
  idfe_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (!in_empty),
    .in_data  (cls_head),
    .in_pop   (in_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (out_data)
  );

  idfe_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (out_data),
    .full    (out_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

`default_nettype wire

// ===== tb/sv/idfe_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idfe_checker: scoreboard for the tag frame extractor
// Watches the byte, result and configuration channels, keeps its own frame
// walker to predict each result, and compares every popped result with the
// oldest prediction.
// ----------------------------------------------------------------------------

module idfe_checker
  import idfe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   full,
  input  item_t                  item,
  input  logic                   pop,
  input  logic                   empty,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     errors,
  output int                     outstanding
);

  typedef enum logic [2:0] {
    WALK_HEADER,
    WALK_ID,
    WALK_SIZE,
    WALK_FLAGS,
    WALK_BODY,
    WALK_DONE
  } walk_phase_t;

  // Register copies.
  logic        sel_mode;
  logic [31:0] want_id;

  // Walker state.
  walk_phase_t ph;
  logic [3:0]  pos;
  logic [28:0] tag_left;
  logic [31:0] cur_id;
  logic [27:0] flen;
  logic [27:0] body_left;
  logic        hit;

  result_t expected_results[$];
  int      fail_count = 0;

  task automatic restart_walk();
    ph        = WALK_HEADER;
    pos       = '0;
    tag_left  = '0;
    cur_id    = '0;
    flen      = '0;
    body_left = '0;
    hit       = 1'b0;
  endtask

  // Parsing stops here; in get mode that means the wanted frame was missed.
  task automatic stop_walk(output bit got, output result_t r);
    ph  = WALK_DONE;
    got = 1'b0;
    r   = '0;
    if (sel_mode) begin
      got             = 1'b1;
      r.kind          = KIND_NOT_FOUND;
      r.frame_id      = want_id;
      r.content_byte  = 8'h00;
      r.last_of_frame = 1'b1;
    end
  endtask

  // Charge the finished frame against the tag size and decide what follows.
  task automatic close_frame(inout bit got, inout result_t r);
    logic [28:0] cost;
    cost = FRAME_OVERHEAD + ((flen != 28'd0) ? {1'b0, flen - 28'd1} : 29'd0);
    if (sel_mode && hit) begin
      ph = WALK_DONE;
      return;
    end
    tag_left = (tag_left > cost) ? tag_left - cost : 29'd0;
    ph  = WALK_ID;
    pos = '0;
    if (tag_left == 29'd0) begin
      if (!got) stop_walk(got, r);
      else ph = WALK_DONE;
    end
  endtask

  task automatic walk_byte(input item_t it, output bit got, output result_t r);
    logic [7:0] b;
    bit         show;
    b    = it.data_byte;
    show = !sel_mode;
    got  = 1'b0;
    r    = '0;
    if (it.new_file) restart_walk();
    case (ph)
      WALK_HEADER: begin
        if (pos == TAG_SIZE_POS) tag_left = {22'd0, b[6:0]};
        else if (pos > TAG_SIZE_POS) tag_left = {tag_left[21:0], b[6:0]};
        pos++;
        if (pos >= HEADER_BYTES) begin
          pos = '0;
          ph  = WALK_ID;
          if (tag_left == 29'd0) stop_walk(got, r);
        end
      end
      WALK_ID: begin
        if (pos == 4'd0 && (b < CHAR_A || b > CHAR_Z)) begin
          stop_walk(got, r);
        end else begin
          cur_id = {cur_id[23:0], b};
          pos++;
          if (pos >= ID_BYTES) begin
            pos  = '0;
            flen = '0;
            ph   = WALK_SIZE;
          end
        end
      end
      WALK_SIZE: begin
        flen = {flen[20:0], b[6:0]};
        pos++;
        if (pos >= SIZE_BYTES) begin
          pos = '0;
          ph  = WALK_FLAGS;
        end
      end
      WALK_FLAGS: begin
        pos++;
        if (pos >= FLAG_BYTES) begin
          pos       = '0;
          body_left = (flen != 28'd0) ? flen - 28'd1 : 28'd0;
          hit       = (cur_id == want_id);
          if (show || hit) begin
            got             = 1'b1;
            r.kind          = KIND_START;
            r.frame_id      = cur_id;
            r.content_byte  = 8'h00;
            r.last_of_frame = (body_left == 28'd0);
          end
          if (body_left == 28'd0) close_frame(got, r);
          else ph = WALK_BODY;
        end
      end
      WALK_BODY: begin
        if (show || hit) begin
          got             = 1'b1;
          r.kind          = KIND_BODY;
          r.frame_id      = cur_id;
          r.content_byte  = b;
          r.last_of_frame = (body_left == 28'd1);
        end
        if (body_left > 28'd0) body_left--;
        if (body_left == 28'd0) close_frame(got, r);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
    end
  endtask

  always @(posedge clk) begin : watch
    bit      got;
    result_t predicted;
    result_t oldest;
    if (rst) begin
      restart_walk();
      sel_mode = 1'b0;
      want_id  = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SELECT_MODE: sel_mode = cfg_data[0];
          CFG_WANTED_ID:   want_id  = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        walk_byte(item, got, predicted);
        if (got) expected_results.push_back(predicted);
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result with nothing expected: kind %0d, id 0x%08h, byte 0x%02h",
                 result.kind, result.frame_id, result.content_byte);
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", 32'(oldest.kind), 32'(result.kind));
          check_field("frame_id", oldest.frame_id, result.frame_id);
          check_field("content_byte", 32'(oldest.content_byte), 32'(result.content_byte));
          check_field("last_of_frame", 32'(oldest.last_of_frame),
                      32'(result.last_of_frame));
        end
      end
    end
    errors      <= fail_count;
    outstanding <= expected_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the tag frame extractor
// Builds a stream of tagged files (mostly well formed, some truncated or
// noisy), feeds it byte by byte in phases with different register settings,
// and lets a checker beside the block predict and compare every result.
// ----------------------------------------------------------------------------

module tb_top;
  import idfe_pkg::*;

  localparam int BYTES_WANTED   = 1600;  // generated file bytes after the opening
  localparam int PHASES         = 8;     // register settings after the opening
  localparam int DRAIN_CYCLES   = 20;    // covers bytes still queued inside the block
  localparam int RX_HOLD_CYCLES = 500;   // long receiver hold-off that fills the block
  localparam int STALL_LIMIT    = 5000;  // cycles without any transfer before giving up

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  item_t                  item;
  logic                   pop;
  logic                   empty;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_data;

  int errors;
  int outstanding;

  // The whole byte stream is built up front and then sent in phases.
  item_t file_bytes[$];
  int    opening_len;
  int    files_built;
  int    bytes_sent;
  int    results_taken;
  int    cfg_writes;

  // Set by the byte sender for the phase in which the receiver should stall
  // for a long stretch; read by the result taker only.
  bit stall_rx;
  bit no_tx_gaps;

  // Frame IDs drawn by the generator. Some differ from others only in their
  // last character, so a match has to look at all four bytes.
  logic [31:0] id_pool[6] = '{"TIT2", "TIT3", "TPE1", "XIT2", "AAAA", "ZZZZ"};

  id3v2_frame_extractor u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  idfe_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .pop         (pop),
    .empty       (empty),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stream building
  // --------------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] b, input logic nf);
    item_t it;
    it.data_byte = b;
    it.new_file  = nf;
    file_bytes.push_back(it);
  endtask

  // Sizes travel as four 7-bit groups. The top bit of each byte is random,
  // since the block has to mask it away.
  task automatic put_size(input logic [27:0] v);
    logic [7:0] b;
    for (int i = 3; i >= 0; i--) begin
      b    = {1'b0, v[7*i +: 7]};
      b[7] = 1'($urandom_range(0, 1));
      put_byte(b, 1'b0);
    end
  endtask

  // One frame: ID, size, two flag bytes and the encoding byte, then as many
  // body bytes as asked for (fewer than the size for a cut-off frame).
  task automatic put_frame(input logic [31:0] id, input logic [27:0] size,
                           input int body_bytes);
    for (int i = 3; i >= 0; i--) put_byte(id[8*i +: 8], 1'b0);
    put_size(size);
    repeat (3) put_byte(8'($urandom), 1'b0);
    repeat (body_bytes) put_byte(8'($urandom), 1'b0);
  endtask

  task automatic build_file();
    int          frames;
    int          lens[6];
    logic [31:0] ids[6];
    int          cost;
    logic [27:0] tag;
    bit          cut_off;
    cost = 0;

    // Now and then some noise goes in front; a set new_file bit in it starts
    // a header that the real header then restarts.
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6))
        put_byte(8'($urandom), 1'($urandom_range(0, 7) == 0));
    end

    frames = $urandom_range(0, 5);
    for (int i = 0; i < frames; i++) begin
      lens[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      if ($urandom_range(0, 4) != 0) begin
        ids[i] = id_pool[$urandom_range(0, 5)];
      end else begin
        // Only the first ID character is checked, so the rest may be anything.
        ids[i] = {8'($urandom_range(CHAR_A, CHAR_Z)), 24'($urandom)};
      end
      cost += 11 + ((lens[i] > 0) ? lens[i] - 1 : 0);
    end
    cut_off = ($urandom_range(0, 15) == 0);

    // Mostly the tag size covers the frames exactly; otherwise it is zero,
    // the largest value, too long (parsing runs into what follows) or too
    // short (the count runs out inside a frame).
    case ($urandom_range(0, 9))
      0:       tag = 28'd0;
      1:       tag = 28'h0FFFFFFF;
      2:       tag = 28'(cost + $urandom_range(1, 30));
      3:       tag = 28'((cost > 0) ? $urandom_range(1, cost) : 0);
      default: tag = 28'(cost);
    endcase

    put_byte(8'($urandom), 1'b1);
    repeat (5) put_byte(8'($urandom), 1'b0);
    put_size(tag);

    for (int i = 0; i < frames; i++) begin
      put_frame(ids[i], 28'(lens[i]), (lens[i] > 0) ? lens[i] - 1 : 0);
    end

    // A frame announcing a huge body that the next file cuts short.
    if (cut_off) begin
      put_frame(id_pool[$urandom_range(0, 5)], 28'($urandom) | 28'h100,
                $urandom_range(1, 8));
      return;
    end

    case ($urandom_range(0, 3))
      0: ;
      1: repeat ($urandom_range(1, 4)) put_byte(8'h00, 1'b0);
      2: begin
        case ($urandom_range(0, 4))
          0:       put_byte(8'h40, 1'b0);  // just below 'A'
          1:       put_byte(8'h5B, 1'b0);  // just above 'Z'
          2:       put_byte(8'hFF, 1'b0);
          3:       put_byte(8'h61, 1'b0);  // lower case
          default: put_byte(8'($urandom), 1'b0);
        endcase
      end
      default: repeat ($urandom_range(1, 4)) put_byte(8'($urandom), 1'b0);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Push stays high after a transfer so that back-to-back bytes never lower
  // and raise it in one step; whoever sends the last byte lowers it.
  task automatic send_byte(input item_t it);
    int gap;
    gap = no_tx_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // The first edge makes sure the checker has counted the last byte's
  // result; the drain lets bytes that give no result leave the block too.
  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------

  initial begin : byte_sender
    int          generated;
    int          lo;
    int          hi;
    logic        mode;
    logic [31:0] wanted;

    rst        <= 1'b1;
    push       <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    stall_rx   <= 1'b0;
    no_tx_gaps  = 1'b0;
    bytes_sent  = 0;
    cfg_writes  = 0;
    files_built = 0;

    // Opening part, sent with the registers at their reset values (show all).
    // A tag of size zero whose size bytes all have the top bit set: parsing
    // ends right after the header.
    put_byte("I", 1'b1); put_byte("D", 1'b0); put_byte("3", 1'b0);
    put_byte(8'h04, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
    repeat (4) put_byte(8'h80, 1'b0);
    // The largest tag size, all header bytes at 0xFF.
    put_byte(8'hFF, 1'b1);
    repeat (9) put_byte(8'hFF, 1'b0);
    // First ID character 'A', second 'Z', the other two outside the letters;
    // size zero, so an empty frame whose start is also its last result.
    put_byte("A", 1'b0); put_byte("Z", 1'b0); put_byte(8'h00, 1'b0); put_byte(8'hFF, 1'b0);
    repeat (4) put_byte(8'h80, 1'b0);
    repeat (3) put_byte(8'hFF, 1'b0);
    // A frame of size three: two body bytes, the second marked last.
    repeat (4) put_byte("Z", 1'b0);
    put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h03, 1'b0);
    repeat (3) put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0); put_byte(8'hFF, 1'b0);
    // A first ID byte just below 'A' ends the tag.
    put_byte(8'h40, 1'b0);
    opening_len = file_bytes.size();

    while (file_bytes.size() - opening_len < BYTES_WANTED) begin
      build_file();
      files_built++;
    end
    generated = file_bytes.size() - opening_len;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < opening_len; i++) send_byte(file_bytes[i]);
    push <= 1'b0;

    // Each phase waits until everything has come out, then changes the
    // registers. Phase edges fall anywhere in the stream, so the mode also
    // changes in the middle of frames.
    for (int p = 1; p <= PHASES; p++) begin
      wait_idle();
      case (p)
        2:       begin mode = 1'b0; wanted = 32'hFFFF_FFFF; end
        3:       begin mode = 1'b1; wanted = 32'h0000_0000; end
        4:       begin mode = 1'b1; wanted = 32'hFFFF_FFFF; end
        6:       begin mode = 1'b0; wanted = id_pool[$urandom_range(0, 5)]; end
        default: begin mode = 1'b1; wanted = id_pool[$urandom_range(0, 5)]; end
      endcase
      write_reg(CFG_WANTED_ID, wanted);
      write_reg(CFG_SELECT_MODE, {31'd0, mode});

      // Phase two sends without gaps while the receiver holds off, so the
      // block fills up and has to stall its input. Phase six also runs
      // without gaps but with a normal receiver.
      no_tx_gaps = (p == 2) || (p == 6);
      if (p == 2) stall_rx <= 1'b1;

      lo = opening_len + (generated * (p - 1)) / PHASES;
      hi = opening_len + (generated * p) / PHASES;
      for (int i = lo; i < hi; i++) send_byte(file_bytes[i]);
      push <= 1'b0;
      if (p == 2) stall_rx <= 1'b0;
    end

    wait_idle();

    $display("Run covered %0d bytes (%0d generated files) in %0d register settings,",
             bytes_sent, files_built, PHASES + 1);
    $display("with %0d results checked and %0d register writes.",
             results_taken, cfg_writes);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result taker: a random wait before each result, stretches with no wait
  // at all, and one long hold-off when the sender asks for it.
  initial begin : result_taker
    int wait_n;
    bit held;
    pop          <= 1'b0;
    held          = 1'b0;
    results_taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_rx && !held) begin
        wait_n = RX_HOLD_CYCLES;
        held   = 1'b1;
      end else if ((results_taken / 150) % 3 == 1) begin
        wait_n = 0;
      end else begin
        wait_n = $urandom_range(0, 19);
      end
      if (wait_n > 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      results_taken++;
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== id3v2_frame_extractor.f =====
sv/idfe_pkg.sv
sv/idfe_fifo.sv
sv/idfe_parser.sv
sv/id3v2_frame_extractor.sv
tb/sv/idfe_checker.sv
tb/sv/tb_top.sv
